// ----- rtl/ecc_psm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_psm_pkg
// Shared types and constants of the point scalar multiplier.
// ----------------------------------------------------------------------------
package ecc_psm_pkg;

  localparam int FIELD_BITS_DEF  = 32;
  localparam int SCALAR_BITS_DEF = 63;

  typedef enum logic {
    CFG_CURVE_A       = 1'b0,
    CFG_FIELD_MODULUS = 1'b1
  } eps_cfg_idx_t;

  // status of the inverse unit
  typedef struct packed {
    logic done;
    logic ok;
  } eps_inv_stat_t;

endpackage

// ----- rtl/ecc_point_scalar_multiply.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_point_scalar_multiply
// Scalar times point on y^2 = x^3 + a*x + b mod n, lsb-first double-and-add.
// ----------------------------------------------------------------------------
//  channel   signals                                        handshake
//  request   point_x point_y point_at_infinity scalar       start & !busy
//  result    result_x result_y result_at_infinity           done (1 cycle)
//            no_inverse_error
//  config    cfg_index cfg_data                             cfg_write
//
//  One request at a time; busy stays high until the done cycle.
//  Each scalar bit costs a point addition (if set) and a doubling; each one
//  whose operands are both finite and not negatives of each other uses an
//  inverse by Euclid steps plus three (addition) or four (doubling) serial
//  multiplies.
//  Synchronous reset; results cannot be held off.
// ----------------------------------------------------------------------------
module ecc_point_scalar_multiply #(
  parameter int FIELD_BITS  = ecc_psm_pkg::FIELD_BITS_DEF,
  parameter int SCALAR_BITS = ecc_psm_pkg::SCALAR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [FIELD_BITS-1:0]  point_x,
  input  logic [FIELD_BITS-1:0]  point_y,
  input  logic                   point_at_infinity,
  input  logic [SCALAR_BITS-1:0] scalar,
  output logic                   done,
  output logic [FIELD_BITS-1:0]  result_x,
  output logic [FIELD_BITS-1:0]  result_y,
  output logic                   result_at_infinity,
  output logic                   no_inverse_error,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [FIELD_BITS-1:0]  cfg_data
);
  import ecc_psm_pkg::*;

  localparam int W = FIELD_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RX, S_RY, S_LOOP, S_CHK, S_SQ, S_T1, S_T2, S_T3,
    S_INV, S_LAM, S_LL, S_X1, S_X2, S_MU, S_WB, S_DONE
  } state_t;

  state_t state;

  logic [W-1:0] cfg_a;
  logic [W-1:0] cfg_n;
  logic [W-1:0] n;
  logic [W-1:0] ca;
  logic [W-1:0] px, py, accx, accy, ax, ay, bx, by, rx, ry;
  logic         pinf, accinf, ainf, binf, rinf;
  logic [SCALAR_BITS-1:0] k;
  logic         err;
  logic         dbl;
  logic [W-1:0] num, den, lam, tmp, x3;

  logic         mul_start;
  logic [W-1:0] mu, mv;
  logic         mul_done;
  logic [W-1:0] mul_prod;
  logic         inv_start;
  eps_inv_stat_t inv_stat;
  logic [W-1:0] inv_res;

  function automatic logic [W-1:0] addm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] md);
    logic [W-1:0] d;
    d = a - b;
    if (a < b) d = d + md;
    return d;
  endfunction

  ecc_psm_mod_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .u     (mu),
    .v     (mv),
    .n     (n),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ecc_psm_mod_inv #(.W(W)) u_inv (
    .clk   (clk),
    .rst   (rst),
    .start (inv_start),
    .v     (den),
    .n     (n),
    .stat  (inv_stat),
    .inv   (inv_res)
  );

  assign busy = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_a <= '0;
      cfg_n <= W'(3);
    end else if (cfg_write) begin
      if (cfg_index == CFG_CURVE_A) cfg_a <= cfg_data;
      else cfg_n <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      mul_start <= 1'b0;
      inv_start <= 1'b0;
      err       <= 1'b0;
      dbl       <= 1'b0;
    end else begin
      done      <= 1'b0;
      mul_start <= 1'b0;
      inv_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n         <= cfg_n;
            px        <= point_x;
            py        <= point_y;
            pinf      <= point_at_infinity;
            k         <= scalar;
            mu        <= W'(1);
            mv        <= cfg_a;
            mul_start <= 1'b1;
            state     <= S_RA;
          end
        end
        S_RA: begin
          if (mul_done) begin
            ca        <= mul_prod;
            mv        <= px;
            mul_start <= 1'b1;
            state     <= S_RX;
          end
        end
        S_RX: begin
          if (mul_done) begin
            px        <= mul_prod;
            mv        <= py;
            mul_start <= 1'b1;
            state     <= S_RY;
          end
        end
        S_RY: begin
          if (mul_done) begin
            py     <= mul_prod;
            accx   <= '0;
            accy   <= '0;
            accinf <= 1'b1;
            err    <= 1'b0;
            state  <= S_LOOP;
          end
        end
        S_LOOP: begin
          ax   <= px;
          ay   <= py;
          ainf <= pinf;
          if (k == '0) begin
            state <= S_DONE;
          end else if (k[0]) begin
            bx    <= accx;
            by    <= accy;
            binf  <= accinf;
            dbl   <= 1'b0;
            state <= S_CHK;
          end else begin
            bx    <= px;
            by    <= py;
            binf  <= pinf;
            dbl   <= 1'b1;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ainf) begin
            rx <= bx; ry <= by; rinf <= binf;
            state <= S_WB;
          end else if (binf) begin
            rx <= ax; ry <= ay; rinf <= 1'b0;
            state <= S_WB;
          end else if (ax == bx && ay == by) begin
            if (ay == '0) begin
              rx <= '0; ry <= '0; rinf <= 1'b1;
              state <= S_WB;
            end else begin
              den       <= addm(ay, ay, n);
              mu        <= ax;
              mv        <= ax;
              mul_start <= 1'b1;
              state     <= S_SQ;
            end
          end else if (ax == bx) begin
            rx <= '0; ry <= '0; rinf <= 1'b1;
            state <= S_WB;
          end else begin
            num       <= subm(by, ay, n);
            den       <= subm(bx, ax, n);
            inv_start <= 1'b1;
            state     <= S_INV;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            tmp   <= mul_prod;
            state <= S_T1;
          end
        end
        S_T1: begin
          num   <= addm(tmp, tmp, n);
          state <= S_T2;
        end
        S_T2: begin
          num   <= addm(num, tmp, n);
          state <= S_T3;
        end
        S_T3: begin
          num       <= addm(num, ca, n);
          inv_start <= 1'b1;
          state     <= S_INV;
        end
        S_INV: begin
          if (inv_stat.done) begin
            if (!inv_stat.ok) begin
              err <= 1'b1;
              rx <= '0; ry <= '0; rinf <= 1'b1;
              state <= S_WB;
            end else begin
              mu        <= num;
              mv        <= inv_res;
              mul_start <= 1'b1;
              state     <= S_LAM;
            end
          end
        end
        S_LAM: begin
          if (mul_done) begin
            lam       <= mul_prod;
            mu        <= mul_prod;
            mv        <= mul_prod;
            mul_start <= 1'b1;
            state     <= S_LL;
          end
        end
        S_LL: begin
          if (mul_done) begin
            tmp   <= subm(mul_prod, ax, n);
            state <= S_X1;
          end
        end
        S_X1: begin
          x3    <= subm(tmp, bx, n);
          state <= S_X2;
        end
        S_X2: begin
          mu        <= lam;
          mv        <= subm(ax, x3, n);
          mul_start <= 1'b1;
          state     <= S_MU;
        end
        S_MU: begin
          if (mul_done) begin
            rx    <= x3;
            ry    <= subm(mul_prod, ay, n);
            rinf  <= 1'b0;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (!dbl) begin
            accx   <= rx;
            accy   <= ry;
            accinf <= rinf;
            if (err) begin
              state <= S_DONE;
            end else begin
              ax <= px; ay <= py; ainf <= pinf;
              bx <= px; by <= py; binf <= pinf;
              dbl   <= 1'b1;
              state <= S_CHK;
            end
          end else begin
            px   <= rx;
            py   <= ry;
            pinf <= rinf;
            k    <= k >> 1;
            state <= (rinf || err) ? S_DONE : S_LOOP;
          end
        end
        S_DONE: begin
          done               <= 1'b1;
          result_x           <= (err || accinf) ? '0 : accx;
          result_y           <= (err || accinf) ? '0 : accy;
          result_at_infinity <= !err && accinf;
          no_inverse_error   <= err;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/ecc_psm_mod_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_psm_mod_mul
// Bit-serial modular multiplier: prod = u * v mod n, one bit of v per cycle,
// msb first. With u = 1 it reduces v modulo n.
// ----------------------------------------------------------------------------
module ecc_psm_mod_mul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] u,
  input  logic [W-1:0] v,
  input  logic [W-1:0] n,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic         run;
  logic [CW-1:0] cnt;
  logic [W-1:0] acc;
  logic [W-1:0] ureg;
  logic [W-1:0] vsh;
  logic [W-1:0] acc_next;
  logic         n_small;

  function automatic logic [W-1:0] addm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  assign n_small  = (n < W'(2));
  assign acc_next = addm(addm(acc, acc, n), vsh[W-1] ? ureg : '0, n);
  assign prod     = n_small ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        cnt  <= CW'(W - 1);
        acc  <= '0;
        ureg <= u;
        vsh  <= v;
      end else if (run) begin
        acc <= acc_next;
        vsh <= {vsh[W-2:0], 1'b0};
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ecc_psm_mod_inv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_psm_mod_inv
// Modular inverse by extended Euclid. Each quotient is found by bit-serial
// restoring division while q * t1 mod n is accumulated from the same bits.
// ----------------------------------------------------------------------------
module ecc_psm_mod_inv #(
  parameter int W = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [W-1:0]               v,
  input  logic [W-1:0]               n,
  output ecc_psm_pkg::eps_inv_stat_t stat,
  output logic [W-1:0]               inv
);
  import ecc_psm_pkg::*;

  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {
    I_IDLE,
    I_DIV,
    I_UPD,
    I_FIN
  } inv_state_t;

  inv_state_t    state;
  logic          fail;
  logic [W-1:0]  nreg;
  logic [W-1:0]  r0;
  logic [W-1:0]  r1;
  logic [W-1:0]  t0;
  logic [W-1:0]  t1;
  logic [W:0]    rem;
  logic [W-1:0]  m;
  logic [W-1:0]  sh;
  logic [CW-1:0] cnt;
  logic [W:0]    remb;
  logic          ge;

  function automatic logic [W-1:0] addm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] md);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, md}) s = s - {1'b0, md};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] a, input logic [W-1:0] b,
                                        input logic [W-1:0] md);
    logic [W-1:0] d;
    d = a - b;
    if (a < b) d = d + md;
    return d;
  endfunction

  assign remb      = {rem[W-1:0], sh[W-1]};
  assign ge        = (remb >= {1'b0, r1});
  assign stat.done = (state == I_FIN);
  assign stat.ok   = !fail && (r0 == W'(1));
  assign inv       = t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      fail  <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        I_IDLE: begin
          if (start) begin
            nreg <= n;
            r0   <= n;
            r1   <= v;
            t0   <= '0;
            t1   <= W'(1);
            sh   <= n;
            rem  <= '0;
            m    <= '0;
            cnt  <= CW'(W - 1);
            fail <= (n < W'(2)) || (v == '0);
            state <= ((n < W'(2)) || (v == '0)) ? I_FIN : I_DIV;
          end
        end
        I_DIV: begin
          rem <= ge ? remb - {1'b0, r1} : remb;
          m   <= addm(addm(m, m, nreg), ge ? t1 : '0, nreg);
          sh  <= {sh[W-2:0], 1'b0};
          if (cnt == '0) state <= I_UPD;
          else cnt <= cnt - 1'b1;
        end
        I_UPD: begin
          r0  <= r1;
          r1  <= rem[W-1:0];
          t0  <= t1;
          t1  <= subm(t0, m, nreg);
          sh  <= r1;
          rem <= '0;
          m   <= '0;
          cnt <= CW'(W - 1);
          state <= (rem == '0) ? I_FIN : I_DIV;
        end
        I_FIN: begin
          state <= I_IDLE;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/ecc_point_scalar_multiply_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecc_point_scalar_multiply_tb
// Self-checking bench for the point scalar multiplier. Each request is run
// through a behavioral double-and-add model under the current curve settings.
// Every done cycle is compared field by field with the oldest expected point.
// The curve settings are changed between request batches, while the block is
// idle, and cover prime, non-prime and degenerate moduli.
// ----------------------------------------------------------------------------
module ecc_point_scalar_multiply_tb;
  import ecc_psm_pkg::*;

  localparam int FB = FIELD_BITS_DEF;
  localparam int SB = SCALAR_BITS_DEF;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    bit          inf;
  } ec_point_t;

  typedef struct {
    logic [FB-1:0] px;
    logic [FB-1:0] py;
    logic          pinf;
    logic [SB-1:0] k;
  } mult_req_t;

  typedef struct {
    logic [FB-1:0] rx;
    logic [FB-1:0] ry;
    logic          rinf;
    logic          rerr;
  } mult_res_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [FB-1:0] point_x = '0;
  logic [FB-1:0] point_y = '0;
  logic          point_at_infinity = 1'b0;
  logic [SB-1:0] scalar = '0;
  logic          done;
  logic [FB-1:0] result_x;
  logic [FB-1:0] result_y;
  logic          result_at_infinity;
  logic          no_inverse_error;
  logic          cfg_write = 1'b0;
  logic          cfg_index = CFG_CURVE_A;
  logic [FB-1:0] cfg_data = '0;

  logic [63:0]   curve_a_q = 0;
  logic [63:0]   modulus_q = 3;
  mult_req_t     pending_reqs[$];
  mult_res_t     expected_pts[$];
  mult_req_t     cur_req;
  int            gap_cnt = 0;
  int            mismatches = 0;

  ecc_point_scalar_multiply i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_at_infinity(point_at_infinity),
    .scalar(scalar), .done(done), .result_x(result_x), .result_y(result_y),
    .result_at_infinity(result_at_infinity), .no_inverse_error(no_inverse_error),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #250_000_000;
    $display("ecc_point_scalar_multiply verification failed");
    $finish;
  end

  function automatic logic [63:0] fred(logic [63:0] v, logic [63:0] n);
    return (n < 2) ? 64'd0 : v % n;
  endfunction

  function automatic logic [63:0] fadd(logic [63:0] u, logic [63:0] v, logic [63:0] n);
    logic [64:0] s;
    s = 65'(u) + 65'(v);
    if (n < 2) return 0;
    return (s >= 65'(n)) ? 64'(s - 65'(n)) : s[63:0];
  endfunction

  function automatic logic [63:0] fsub(logic [63:0] u, logic [63:0] v, logic [63:0] n);
    if (n < 2) return 0;
    return (u >= v) ? u - v : u + (n - v);
  endfunction

  function automatic logic [63:0] fmul(logic [63:0] u, logic [63:0] v, logic [63:0] n);
    logic [127:0] p;
    p = 128'(u) * 128'(v);
    if (n < 2) return 0;
    return 64'(p % 128'(n));
  endfunction

  function automatic logic [63:0] finv(logic [63:0] v, logic [63:0] n, output bit ok);
    logic [63:0] r0, r1, t0, t1, q, tmp;
    ok = 0;
    if (n < 2 || v == 0) return 0;
    r0 = n; r1 = v; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = fsub(t0, fmul(fred(q, n), t1, n), n);
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return 0;
    ok = 1;
    return t0;
  endfunction

  function automatic ec_point_t point_sum(ec_point_t p, ec_point_t q, logic [63:0] a,
                                          logic [63:0] n, inout bit err);
    logic [63:0] num, den, inv, lam, x3;
    bit ok;
    ec_point_t r;
    r.x = 0; r.y = 0; r.inf = 1;
    if (p.inf) return q;
    if (q.inf) return p;
    if (p.x == q.x && p.y == q.y) begin
      if (p.y == 0) return r;
      num = fmul(p.x, p.x, n);
      num = fadd(fadd(fadd(num, num, n), num, n), a, n);
      den = fadd(p.y, p.y, n);
    end else begin
      if (p.x == q.x) return r;
      num = fsub(q.y, p.y, n);
      den = fsub(q.x, p.x, n);
    end
    inv = finv(den, n, ok);
    if (!ok) begin
      err = 1;
      return r;
    end
    lam = fmul(num, inv, n);
    x3 = fsub(fsub(fmul(lam, lam, n), p.x, n), q.x, n);
    r.y = fsub(fmul(lam, fsub(p.x, x3, n), n), p.y, n);
    r.x = x3;
    r.inf = 0;
    return r;
  endfunction

  function automatic mult_res_t scalar_mult(mult_req_t rq);
    ec_point_t p, acc;
    logic [63:0] n, a, k;
    bit err;
    mult_res_t r;
    n = modulus_q;
    a = fred(curve_a_q, n);
    err = 0;
    k = 64'(rq.k);
    p.x = fred(64'(rq.px), n); p.y = fred(64'(rq.py), n); p.inf = rq.pinf;
    acc.x = 0; acc.y = 0; acc.inf = 1;
    while (k != 0 && !err) begin
      if (k[0]) acc = point_sum(p, acc, a, n, err);
      if (err) break;
      p = point_sum(p, p, a, n, err);
      k = k >> 1;
      if (p.inf) break;
    end
    if (err) begin
      r.rx = 0; r.ry = 0; r.rinf = 0; r.rerr = 1;
    end else begin
      r.rx = acc.inf ? 0 : acc.x[FB-1:0];
      r.ry = acc.inf ? 0 : acc.y[FB-1:0];
      r.rinf = acc.inf;
      r.rerr = 0;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_pts.push_back(scalar_mult(cur_req));
      start <= 1'b0;
      gap_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    end else if (!start) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        point_x <= cur_req.px;
        point_y <= cur_req.py;
        point_at_infinity <= cur_req.pinf;
        scalar <= cur_req.k;
        start <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    mult_res_t e;
    if (!rst && done) begin
      if (expected_pts.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result x=%h y=%h", result_x, result_y);
      end else begin
        e = expected_pts.pop_front();
        if (e.rx !== result_x || e.ry !== result_y || e.rinf !== result_at_infinity ||
            e.rerr !== no_inverse_error) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp x=%h y=%h inf=%b err=%b got x=%h y=%h inf=%b err=%b",
                     e.rx, e.ry, e.rinf, e.rerr, result_x, result_y,
                     result_at_infinity, no_inverse_error);
        end
      end
    end
  end

  task automatic write_reg(eps_cfg_idx_t idx, logic [FB-1:0] d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CURVE_A) curve_a_q = 64'(d);
    else modulus_q = 64'(d);
  endtask

  task automatic add_req(logic [FB-1:0] x, logic [FB-1:0] y, logic inf, logic [SB-1:0] k);
    mult_req_t r;
    r.px = x; r.py = y; r.pinf = inf; r.k = k;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [SB-1:0] rand_scalar();
    logic [SB-1:0] k;
    k = SB'({$urandom, $urandom});
    case ($urandom_range(0, 15))
      0: return k;
      1, 2, 3: return SB'(k[15:0]);
      default: return SB'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [FB-1:0] rand_coord();
    if ($urandom_range(0, 7) == 0) return FB'($urandom);
    return FB'(fred(64'($urandom), modulus_q));
  endfunction

  logic [FB-1:0] cfg_a_tbl[8] = '{0, 2, 32'hFFFF_FFFF, 7, 3, 1, 32'h1234_5678, 0};
  logic [FB-1:0] cfg_n_tbl[8] = '{3, 97, 32'hFFFF_FFFB, 32'hFFFF_FFFF,
                                  0, 1, 65537, 91};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_CURVE_A, cfg_a_tbl[ph]);
        write_reg(CFG_FIELD_MODULUS, cfg_n_tbl[ph]);
      end
      if (ph == 0 || ph == 2 || ph == 3) begin
        add_req(1, 2, 1'b0, SB'(0));
        add_req(1, 2, 1'b0, SB'(1));
        add_req(5, 7, 1'b0, SB'(2));
        add_req(5, 7, 1'b0, SB'(3));
        add_req(9, 11, 1'b1, {SB{1'b1}});
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, SB'(5));
        add_req(4, 0, 1'b0, SB'(2));
        add_req(32'h8000_0001, 32'h7FFF_FFFE, 1'b0, {SB{1'b1}});
        add_req(0, 0, 1'b0, {1'b1, {(SB-1){1'b0}}});
      end
      for (int i = 0; i < 9; i++)
        add_req(rand_coord(), rand_coord(), $urandom_range(0, 15) == 0, rand_scalar());
      while (pending_reqs.size() != 0 || start || expected_pts.size() != 0 || busy)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_pts.size() == 0)
      $display("ecc_point_scalar_multiply verification clean");
    else
      $display("ecc_point_scalar_multiply verification failed");
    $finish;
  end

endmodule
